>>> hw/rtl/pir_pkg.sv
//------------------------------------------------------------------------------
// pir_pkg
// shared types and constants of the projective image resampler
//------------------------------------------------------------------------------
package pir_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_ROW0_PAIR  = 3'd0;
    localparam logic [2:0] REG_ROW0_ROW1  = 3'd1;
    localparam logic [2:0] REG_ROW1_PAIR  = 3'd2;
    localparam logic [2:0] REG_ROW2_PAIR  = 3'd3;
    localparam logic [2:0] REG_LAST       = 3'd4;
    localparam logic [2:0] REG_SRC_SIZE   = 3'd5;
    localparam logic [2:0] REG_DST_SIZE   = 3'd6;
    localparam logic [2:0] REG_BACKGROUND = 3'd7;

    // request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_MAP  = 1'b1;

    // input tdata width: x, y, run, four channels = 103 bits -> 104
    localparam int IN_DATA_W = 104;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_CHECK,
        ST_DIV,
        ST_FETCH,
        ST_ACC,
        ST_NORM,
        ST_EMIT
    } t_state;

    // configuration image seen by the core
    typedef struct packed {
        logic signed [31:0] e0, e1, e2, e3, e4, e5, e6, e7, e8;
        logic [15:0]        src_w;
        logic [15:0]        src_h;
        logic [15:0]        dst_w;
        logic [15:0]        dst_h;
        logic [31:0]        bg;
    } t_cfg;

endpackage

>>> hw/rtl/projective_image_resampler.sv
//------------------------------------------------------------------------------
// projective_image_resampler
// perspective warp of a stored source image with four neighbour blending
//------------------------------------------------------------------------------
// Usage: write the matrix, sizes and background on the cfg channel while idle.
// Load requests on s_axis (tuser=0) write one source pixel and give no
// result. Map requests (tuser=1) produce a run of pixels on m_axis, tlast on
// the final one; tuser of the result flags a background pixel.
// An inside pixel passes through products, sums and range check, the shared
// serial divider (X/W then Y/W), one read per used neighbour on the single
// memory read port (skipped neighbours are passed over), normalization of
// four channels one quotient bit per cycle, and emit. A background pixel
// goes from the range check straight to emit. A new request is taken only
// once the previous run has fully left the output register. At reset the
// config registers take their default values; the image memory holds no
// defined data until loaded. When the receiver stalls the result is held in
// the output register and the walk waits.
//------------------------------------------------------------------------------
module projective_image_resampler #(
    parameter int MAX_SRC_WIDTH  = 128,
    parameter int MAX_SRC_HEIGHT = 128,
    parameter int MAX_RUN        = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // cfg channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    // request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: pix_x, pix_y, run_length, chan_blue, chan_green, chan_red, chan_alpha
    input  logic [pir_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: req_type
    input  logic         s_axis_tuser,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: out_pixel
    output logic [31:0]  m_axis_tdata,
    // tuser: used_background
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);
    localparam int XW  = $clog2(MAX_SRC_WIDTH);
    localparam int YW  = $clog2(MAX_SRC_HEIGHT);
    localparam int AW  = XW + YW;
    localparam int RW  = $clog2(MAX_RUN + 1);
    localparam int QW  = 26;
    localparam int DW  = 68;
    localparam int SXW = 52 + XW;
    localparam int SYW = 52 + YW;

    pir_pkg::t_state r_state, n_state;
    pir_pkg::t_cfg   r_cfg;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.e0 <= 32'sd0; r_cfg.e1 <= 32'sd1; r_cfg.e2 <= 32'sd0;
            r_cfg.e3 <= 32'sd0; r_cfg.e4 <= 32'sd65536; r_cfg.e5 <= 32'sd0;
            r_cfg.e6 <= 32'sd0; r_cfg.e7 <= 32'sd0; r_cfg.e8 <= 32'sd65536;
            r_cfg.src_w <= 16'd128; r_cfg.src_h <= 16'd128;
            r_cfg.dst_w <= '0; r_cfg.dst_h <= '0; r_cfg.bg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pir_pkg::REG_ROW0_PAIR: begin
                    r_cfg.e0 <= i_cfg_data[31:0]; r_cfg.e1 <= i_cfg_data[63:32];
                end
                pir_pkg::REG_ROW0_ROW1: begin
                    r_cfg.e2 <= i_cfg_data[31:0]; r_cfg.e3 <= i_cfg_data[63:32];
                end
                pir_pkg::REG_ROW1_PAIR: begin
                    r_cfg.e4 <= i_cfg_data[31:0]; r_cfg.e5 <= i_cfg_data[63:32];
                end
                pir_pkg::REG_ROW2_PAIR: begin
                    r_cfg.e6 <= i_cfg_data[31:0]; r_cfg.e7 <= i_cfg_data[63:32];
                end
                pir_pkg::REG_LAST: r_cfg.e8 <= i_cfg_data[31:0];
                pir_pkg::REG_SRC_SIZE: begin
                    r_cfg.src_w <= i_cfg_data[15:0]; r_cfg.src_h <= i_cfg_data[31:16];
                end
                pir_pkg::REG_DST_SIZE: begin
                    r_cfg.dst_w <= i_cfg_data[15:0]; r_cfg.dst_h <= i_cfg_data[31:16];
                end
                pir_pkg::REG_BACKGROUND: r_cfg.bg <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // request fields
    logic [15:0] w_in_x, w_in_y;
    logic [6:0]  w_in_run;
    assign w_in_x   = s_axis_tdata[15:0];
    assign w_in_y   = s_axis_tdata[31:16];
    assign w_in_run = s_axis_tdata[38:32];

    // clamped source size
    logic [15:0] w_sw, w_sh;
    assign w_sw = (r_cfg.src_w > 16'(MAX_SRC_WIDTH))  ? 16'(MAX_SRC_WIDTH)  : r_cfg.src_w;
    assign w_sh = (r_cfg.src_h > 16'(MAX_SRC_HEIGHT)) ? 16'(MAX_SRC_HEIGHT) : r_cfg.src_h;

    // walk state
    logic [15:0] r_x, r_y;
    logic [RW-1:0] r_left;
    // products and sums
    logic signed [48:0] r_p [6];
    logic signed [50:0] r_X, r_Y, r_W;
    logic r_bg;
    logic r_div_y;
    logic [QW-1:0] r_qx;
    logic [XW:0] r_ix;
    logic [YW:0] r_iy;
    logic [15:0] r_fx, r_fy;
    logic r_right, r_below;
    logic [1:0] r_nb;
    logic [17:0] r_k;
    logic [41:0] r_acc [4];
    logic [19:0] r_s;
    logic [2:0]  r_ch;
    logic [31:0] r_pix;
    logic [3:0]  r_nstep;
    logic [41:0] r_num;
    logic [7:0]  r_q;

    // output register
    logic r_ovalid;
    logic [31:0] r_odata;
    logic r_ouser, r_olast;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    assign s_axis_tready = (r_state == pir_pkg::ST_IDLE) && !r_ovalid;
    logic w_acc_in;
    assign w_acc_in = s_axis_tvalid && s_axis_tready;

    // raster walk end tests, one bit wider so column 65535 still wraps
    logic w_x_wrap, w_y_end;
    assign w_x_wrap = ({1'b0, r_x} + 17'd1) >= {1'b0, r_cfg.dst_w};
    assign w_y_end  = ({1'b0, r_y} + 17'd1) >= {1'b0, r_cfg.dst_h};

    // image memory
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [63:0]   w_rdata;
    assign w_we = w_acc_in && (s_axis_tuser == pir_pkg::REQ_LOAD)
                  && (w_in_x < 16'(MAX_SRC_WIDTH)) && (w_in_y < 16'(MAX_SRC_HEIGHT));
    assign w_waddr = {w_in_y[YW-1:0], w_in_x[XW-1:0]};

    // neighbour select
    logic [XW:0] w_nx;
    logic [YW:0] w_ny;
    always_comb begin
        w_nx = r_ix + ((r_nb == 2'd1 || r_nb == 2'd2) ? (XW+1)'(1) : '0);
        w_ny = r_iy + ((r_nb == 2'd2 || r_nb == 2'd3) ? (YW+1)'(1) : '0);
    end
    assign w_raddr = {w_ny[YW-1:0], w_nx[XW-1:0]};

    pir_image_mem #(.DEPTH(1 << AW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(s_axis_tdata[102:39]),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // divider on magnitudes, X/W started from check, Y/W from the divide state
    logic          w_div_start;
    logic          w_div_busy;
    logic [QW-1:0] w_quot;
    logic [DW-1:0] w_div_num;
    assign w_div_num = (r_state == pir_pkg::ST_DIV) ? DW'(r_Y) : DW'(r_X);
    pir_divider #(.NW(DW), .QW(QW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_div_num << 16),
        .i_den  (DW'(r_W)),
        .o_busy (w_div_busy),
        .o_quot (w_quot)
    );

    // weight of current neighbour
    logic [17:0] w_k;
    always_comb begin
        case (r_nb)
            2'd0:    w_k = 18'd131072 - 18'(r_fx) - 18'(r_fy);
            2'd1:    w_k = 18'd65536 + 18'(r_fx) - 18'(r_fy);
            2'd2:    w_k = 18'(r_fx) + 18'(r_fy);
            default: w_k = 18'd65536 + 18'(r_fy) - 18'(r_fx);
        endcase
    end
    logic w_nb_used;
    always_comb begin
        case (r_nb)
            2'd0:    w_nb_used = 1'b1;
            2'd1:    w_nb_used = r_right;
            2'd2:    w_nb_used = r_right && r_below;
            default: w_nb_used = r_below;
        endcase
    end

    // inside test
    logic w_out;
    logic signed [SXW-1:0] w_sxw;
    logic signed [SYW-1:0] w_syw;
    assign w_sxw = $signed({1'b0, w_sw[XW:0]}) * r_W;
    assign w_syw = $signed({1'b0, w_sh[YW:0]}) * r_W;
    assign w_out = (r_W == 0) || r_X < 0 || r_Y < 0 || r_X >= w_sxw || r_Y >= w_syw;

    // normalize divisor, quotient bit trial
    logic [41:0] w_den, w_trial;
    assign w_den   = 42'(r_s) << (r_nstep[2:0] + 8);
    assign w_trial = r_num - w_den;

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        case (r_state)
            pir_pkg::ST_IDLE:
                if (w_acc_in && s_axis_tuser == pir_pkg::REQ_MAP && w_in_run != '0
                    && w_in_y < r_cfg.dst_h) n_state = pir_pkg::ST_MUL;
            pir_pkg::ST_MUL:   n_state = pir_pkg::ST_SUM;
            pir_pkg::ST_SUM:   n_state = pir_pkg::ST_CHECK;
            pir_pkg::ST_CHECK: begin
                if (w_out) n_state = pir_pkg::ST_EMIT;
                else begin
                    n_state = pir_pkg::ST_DIV;
                    w_div_start = 1'b1;
                end
            end
            pir_pkg::ST_DIV:
                if (!w_div_busy) begin
                    if (!r_div_y) w_div_start = 1'b1;
                    else n_state = pir_pkg::ST_FETCH;
                end
            pir_pkg::ST_FETCH:
                if (r_nb == 2'd3 && !w_nb_used) n_state = pir_pkg::ST_NORM;
                else if (w_nb_used) n_state = pir_pkg::ST_ACC;
            pir_pkg::ST_ACC:
                n_state = (r_nb == 2'd3) ? pir_pkg::ST_NORM : pir_pkg::ST_FETCH;
            pir_pkg::ST_NORM:
                if (r_ch == 3'd3 && r_nstep == 4'd0) n_state = pir_pkg::ST_EMIT;
            pir_pkg::ST_EMIT:
                if (!r_ovalid || m_axis_tready) begin
                    if (r_left == RW'(1)) n_state = pir_pkg::ST_IDLE;
                    else if (w_x_wrap && w_y_end) n_state = pir_pkg::ST_IDLE;
                    else n_state = pir_pkg::ST_MUL;
                end
            default: n_state = pir_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= pir_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // output register
    logic w_emit, w_last;
    assign w_emit = (r_state == pir_pkg::ST_EMIT) && (!r_ovalid || m_axis_tready);
    assign w_last = (r_left == RW'(1)) || (w_x_wrap && w_y_end);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (w_emit) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_odata <= r_bg ? r_cfg.bg : r_pix;
            r_ouser <= r_bg;
            r_olast <= w_last;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            pir_pkg::ST_IDLE: begin
                r_x <= w_in_x;
                r_y <= w_in_y;
                r_left <= (w_in_run > 7'(MAX_RUN)) ? RW'(MAX_RUN) : RW'(w_in_run);
            end
            pir_pkg::ST_MUL: begin
                r_p[0] <= r_cfg.e0 * $signed({1'b0, r_x});
                r_p[1] <= r_cfg.e1 * $signed({1'b0, r_y});
                r_p[2] <= r_cfg.e3 * $signed({1'b0, r_x});
                r_p[3] <= r_cfg.e4 * $signed({1'b0, r_y});
                r_p[4] <= r_cfg.e6 * $signed({1'b0, r_x});
                r_p[5] <= r_cfg.e7 * $signed({1'b0, r_y});
            end
            pir_pkg::ST_SUM: begin
                // sign fold so W ends non-negative
                logic signed [50:0] vx, vy, vw;
                vx = 51'(r_p[0]) + 51'(r_p[1]) + 51'(r_cfg.e2);
                vy = 51'(r_p[2]) + 51'(r_p[3]) + 51'(r_cfg.e5);
                vw = 51'(r_p[4]) + 51'(r_p[5]) + 51'(r_cfg.e8);
                if (vw < 0) begin
                    r_X <= -vx; r_Y <= -vy; r_W <= -vw;
                end else begin
                    r_X <= vx; r_Y <= vy; r_W <= vw;
                end
                r_div_y <= 1'b0;
            end
            pir_pkg::ST_CHECK: begin
                r_bg <= w_out;
            end
            pir_pkg::ST_DIV: begin
                if (!w_div_busy && !r_div_y) begin
                    r_qx <= w_quot;
                    r_div_y <= 1'b1;
                end else if (!w_div_busy) begin
                    r_ix <= (XW+1)'(r_qx[QW-1:16]);
                    r_fx <= r_qx[15:0];
                    r_iy <= (YW+1)'(w_quot[QW-1:16]);
                    r_fy <= w_quot[15:0];
                    r_right <= 16'(r_qx[QW-1:16]) + 16'd1 < w_sw;
                    r_below <= 16'(w_quot[QW-1:16]) + 16'd1 < w_sh;
                    r_nb <= 2'd0;
                    r_s <= '0;
                    for (int c = 0; c < 4; c++) r_acc[c] <= '0;
                end
            end
            pir_pkg::ST_FETCH: begin
                r_k <= w_k;
                if (!w_nb_used) r_nb <= r_nb + 2'd1;
                if (r_nb == 2'd3 && !w_nb_used) begin
                    r_ch <= 3'd0; r_nstep <= 4'd7; r_pix <= '0;
                    r_num <= r_acc[0] + (42'(r_s) << 7); r_q <= '0;
                end
            end
            pir_pkg::ST_ACC: begin
                for (int c = 0; c < 4; c++)
                    r_acc[c] <= r_acc[c] + 42'(w_rdata[16*c +: 16] * r_k);
                r_s <= r_s + 20'(r_k);
                r_nb <= r_nb + 2'd1;
                if (r_nb == 2'd3) begin
                    r_ch <= 3'd0; r_nstep <= 4'd7; r_q <= '0;
                    r_num <= r_acc[0] + 42'(w_rdata[15:0] * r_k)
                             + (42'(r_s + 20'(r_k)) << 7);
                end
            end
            pir_pkg::ST_NORM: begin
                // one quotient bit per cycle, 8 bits plus overflow check
                logic [7:0] q;
                q = r_q;
                if (r_num >= w_den) q[r_nstep[2:0]] = 1'b1;
                if (r_nstep == 4'd0) begin
                    // remaining at or above 256*S after 8 bits means saturation
                    r_pix[8*r_ch[1:0] +: 8] <=
                        ((r_num >= w_den ? w_trial : r_num) >= (42'(r_s) << 8))
                        ? 8'hFF : q;
                    r_ch <= r_ch + 3'd1;
                    r_nstep <= 4'd7;
                    r_q <= '0;
                    if (r_ch != 3'd3)
                        r_num <= r_acc[r_ch[1:0] + 2'd1] + (42'(r_s) << 7);
                end else begin
                    r_q <= q;
                    r_nstep <= r_nstep - 4'd1;
                    if (r_num >= w_den) r_num <= w_trial;
                end
            end
            pir_pkg::ST_EMIT: begin
                if (w_emit) begin
                    r_left <= r_left - 1'b1;
                    if (w_x_wrap) begin
                        r_x <= '0; r_y <= r_y + 1'b1;
                    end else r_x <= r_x + 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule

>>> hw/rtl/pir_divider.sv
//------------------------------------------------------------------------------
// pir_divider
// restoring divider, one quotient bit per cycle
//------------------------------------------------------------------------------
module pir_divider #(
    parameter int NW = 64,
    parameter int QW = 26
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [NW-1:0] i_den,
    output logic          o_busy,
    output logic [QW-1:0] o_quot
);
    localparam int CW = $clog2(QW + 1);

    logic [NW-1:0] r_rem, n_rem;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_den;
    logic [QW-1:0] r_quot;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [NW:0]   w_trial;

    // shift next numerator bit in, subtract when it fits
    always_comb begin
        w_trial = {r_rem, r_num[NW-1]};
        n_rem   = w_trial[NW-1:0];
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_trial[NW-1:0] - r_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(QW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // numerator preshifted so only the low quotient bits are produced
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= NW'(i_num >> QW);
            r_num  <= i_num << (NW - QW);
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_num  <= r_num << 1;
            r_quot <= {r_quot[QW-2:0], ({r_rem, r_num[NW-1]} >= {1'b0, r_den})};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
endmodule

>>> hw/rtl/pir_image_mem.sv
//------------------------------------------------------------------------------
// pir_image_mem
// source pixel store, one write and one registered read port
//------------------------------------------------------------------------------
module pir_image_mem #(
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [63:0]              i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [63:0]              o_rdata
);
    logic [63:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hw/rtl/pir_checker.sv
//------------------------------------------------------------------------------
// pir_checker
// port-level checks of the resampler streams
//------------------------------------------------------------------------------
module pir_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed under stall");

    // no request taken while a result waits
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken with result pending");

    // nothing valid right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a request accepted cannot produce a result in the next cycle
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");
endmodule

bind projective_image_resampler pir_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

>>> bench/projective_image_resampler_tb.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// projective_image_resampler_tb
// loads source pixels and maps destination runs through varied matrices and
// sizes; a scoreboard predicts every output pixel and checks them in order
//------------------------------------------------------------------------------
module projective_image_resampler_tb;

    localparam int SRC_MAX   = 128;
    localparam int RUN_MAX   = 64;
    localparam int LIMIT     = 8000000;
    localparam int SETTLE    = 200;

    typedef struct packed {
        logic        kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [6:0]  run;
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
        logic [15:0] alpha;
    } t_request;

    typedef struct packed {
        logic [31:0] pixel;
        logic        bg;
        logic        last;
    } t_pixel;

    // scoreboard: image copy, register copy and queue of pending pixels
    class warp_scoreboard;
        logic [63:0] regs [0:7];
        logic [63:0] image [SRC_MAX*SRC_MAX];
        bit          written [SRC_MAX*SRC_MAX];
        t_pixel      pending_pixels [$];
        int          errors;

        function new();
            regs[pir_pkg::REG_ROW0_PAIR]  = 64'h1_0000_0000;
            regs[pir_pkg::REG_ROW0_ROW1]  = 0;
            regs[pir_pkg::REG_ROW1_PAIR]  = 64'h1_0000;
            regs[pir_pkg::REG_ROW2_PAIR]  = 0;
            regs[pir_pkg::REG_LAST]       = 64'h1_0000;
            regs[pir_pkg::REG_SRC_SIZE]   = 64'h0080_0080;
            regs[pir_pkg::REG_DST_SIZE]   = 0;
            regs[pir_pkg::REG_BACKGROUND] = 0;
            errors = 0;
        endfunction

        function void note_config(int idx, logic [63:0] v);
            regs[idx] = (idx >= pir_pkg::REG_LAST) ? {32'd0, v[31:0]} : v;
        endfunction

        // one destination pixel; returns 0 if it would read an unloaded entry
        function bit sample(int dx, int dy, output logic [31:0] pix, output logic bg);
            int     e [9];
            longint cx, cy, cw, sw, sh, ix, iy, fx, fy, s, r, w8;
            longint acc [4];
            longint wt [4];
            int     px [4];
            int     py [4];
            bit     ok;
            ok = 1;
            for (int i = 0; i < 4; i++) begin
                e[2*i]   = regs[i][31:0];
                e[2*i+1] = regs[i][63:32];
            end
            e[8] = regs[pir_pkg::REG_LAST][31:0];
            cx = longint'(e[0]) * dx + longint'(e[1]) * dy + e[2];
            cy = longint'(e[3]) * dx + longint'(e[4]) * dy + e[5];
            cw = longint'(e[6]) * dx + longint'(e[7]) * dy + e[8];
            sw = regs[pir_pkg::REG_SRC_SIZE][15:0];
            sh = regs[pir_pkg::REG_SRC_SIZE][31:16];
            if (sw > SRC_MAX) sw = SRC_MAX;
            if (sh > SRC_MAX) sh = SRC_MAX;
            pix = regs[pir_pkg::REG_BACKGROUND][31:0];
            bg = 1;
            if (cw == 0) return 1;
            if (cw < 0) begin
                cx = -cx; cy = -cy; cw = -cw;
            end
            if (cx < 0 || cy < 0 || cx >= sw * cw || cy >= sh * cw) return 1;
            ix = cx / cw; fx = 0; r = cx % cw;
            iy = cy / cw; fy = 0; w8 = cy % cw;
            // long division for the 16 fraction bits
            for (int i = 0; i < 16; i++) begin
                r = r << 1; fx = fx << 1;
                if (r >= cw) begin r -= cw; fx |= 1; end
                w8 = w8 << 1; fy = fy << 1;
                if (w8 >= cw) begin w8 -= cw; fy |= 1; end
            end
            // own, right, diagonal, below neighbours with planar weights
            wt[0] = 131072 - fx - fy;     px[0] = int'(ix);     py[0] = int'(iy);
            wt[1] = 65536 + fx - fy;      px[1] = int'(ix + 1); py[1] = int'(iy);
            wt[2] = fx + fy;              px[2] = int'(ix + 1); py[2] = int'(iy + 1);
            wt[3] = 65536 + fy - fx;      px[3] = int'(ix);     py[3] = int'(iy + 1);
            if (ix + 1 >= sw) begin wt[1] = -1; wt[2] = -1; end
            if (iy + 1 >= sh) begin wt[2] = -1; wt[3] = -1; end
            s = 0;
            for (int c = 0; c < 4; c++) acc[c] = 0;
            for (int n = 0; n < 4; n++) begin
                if (wt[n] >= 0) begin
                    if (!written[py[n]*SRC_MAX + px[n]]) ok = 0;
                    for (int c = 0; c < 4; c++)
                        acc[c] += longint'(image[py[n]*SRC_MAX + px[n]][16*c +: 16]) * wt[n];
                    s += wt[n];
                end
            end
            for (int c = 0; c < 4; c++) begin
                r = (acc[c] + s * 128) / (s * 256);
                if (r > 255) r = 255;
                pix[8*c +: 8] = r[7:0];
            end
            bg = 0;
            return ok;
        endfunction

        // walk a run in raster order; with commit set, queue the pixels
        function bit walk_run(t_request q, bit commit);
            int          x, y, n, dw, dh, k;
            bit          ok;
            t_pixel      p;
            logic [31:0] pix;
            logic        bg;
            x = q.x; y = q.y; n = q.run;
            if (n > RUN_MAX) n = RUN_MAX;
            dw = regs[pir_pkg::REG_DST_SIZE][15:0];
            dh = regs[pir_pkg::REG_DST_SIZE][31:16];
            ok = 1;
            if (n == 0 || y >= dh) return 1;
            k = 0;
            forever begin
                if (!sample(x, y, pix, bg)) ok = 0;
                k++;
                p.pixel = pix; p.bg = bg; p.last = 0;
                if (k >= n) begin
                    p.last = 1;
                    if (commit) pending_pixels.push_back(p);
                    break;
                end
                x++;
                if (x >= dw) begin
                    x = 0; y++;
                    if (y >= dh) begin
                        p.last = 1;
                        if (commit) pending_pixels.push_back(p);
                        break;
                    end
                end
                if (commit) pending_pixels.push_back(p);
            end
            return ok;
        endfunction

        function void note_request(t_request q);
            if (q.kind == pir_pkg::REQ_LOAD) begin
                if (q.x < SRC_MAX && q.y < SRC_MAX) begin
                    image[q.y*SRC_MAX + q.x] = {q.alpha, q.red, q.green, q.blue};
                    written[q.y*SRC_MAX + q.x] = 1;
                end
            end else begin
                void'(walk_run(q, 1));
            end
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_pixel(logic [31:0] d, logic u, logic l);
            t_pixel p;
            if (pending_pixels.size() == 0) begin
                report($sformatf("unexpected pixel %h", d));
                return;
            end
            p = pending_pixels.pop_front();
            if (d !== p.pixel) report($sformatf("pixel %h, want %h", d, p.pixel));
            if (u !== p.bg)    report($sformatf("background flag %b, want %b", u, p.bg));
            if (l !== p.last)  report($sformatf("tlast %b, want %b", l, p.last));
        endtask
    endclass

    logic                          i_clk = 0;
    logic                          i_rst_n = 0;
    logic                          i_cfg_valid = 0;
    logic                          o_cfg_ready;
    logic [2:0]                    i_cfg_index = '0;
    logic [63:0]                   i_cfg_data = '0;
    logic                          s_axis_tvalid = 0;
    logic                          s_axis_tready;
    logic [pir_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
    logic                          s_axis_tuser = 0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 0;
    logic [31:0]                   m_axis_tdata;
    logic                          m_axis_tuser;
    logic                          m_axis_tlast;

    warp_scoreboard sb = new();
    bit             quiet = 0;
    int             cycles = 0;

    projective_image_resampler DUT (.*);

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("projective_image_resampler: mismatch");
            $finish;
        end
    end

    // result side: random stalls and checking
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_pixel(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        m_axis_tready <= quiet || ($urandom_range(99) >= 14);
    end

    task cfg_write(logic [2:0] idx, logic [63:0] v);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_config(idx, v);
    endtask

    task send_request(t_request q);
        if (!quiet && $urandom_range(99) < 14) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= q.kind;
        s_axis_tdata  <= {1'b0, q.alpha, q.red, q.green, q.blue, q.run, q.y, q.x};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(q);
    endtask

    // only maps that read loaded entries go out
    task offer_request(t_request q);
        if (q.kind == pir_pkg::REQ_MAP && !sb.walk_run(q, 0)) return;
        send_request(q);
    endtask

    // wait for every pending pixel, then let trailing work settle
    task drain;
        s_axis_tvalid <= 0;
        i_cfg_valid   <= 0;
        @(posedge i_clk);
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_request make_req(logic kind, int x, int y, int run);
        t_request q;
        q.kind  = kind;
        q.x     = 16'(x);
        q.y     = 16'(y);
        q.run   = 7'(run);
        q.blue  = 16'($urandom);
        q.green = 16'($urandom);
        q.red   = 16'($urandom);
        q.alpha = 16'($urandom);
        return q;
    endfunction

    function automatic logic [31:0] rand_coef(int span);
        int v;
        v = $urandom_range(2 * span) - span;
        return v;
    endfunction

    // random matrix and sizes for one phase
    task random_config(int mode);
        int          e [9];
        logic [63:0] hi;
        for (int i = 0; i < 9; i++) e[i] = 0;
        e[0] = $urandom_range(32'h4000, 32'h18000);
        e[1] = rand_coef(32'h2000);
        e[2] = rand_coef(32'h10000);
        e[3] = rand_coef(32'h2000);
        e[4] = $urandom_range(32'h4000, 32'h18000);
        e[5] = rand_coef(32'h10000);
        e[6] = rand_coef(32'h400);
        e[7] = rand_coef(32'h400);
        e[8] = $urandom_range(32'hC000, 32'h14000);
        if ($urandom_range(1)) for (int i = 0; i < 9; i++) e[i] = -e[i];
        if (mode == 0) for (int i = 0; i < 9; i++) e[i] = $urandom;
        hi = {$urandom, 32'd0};
        cfg_write(pir_pkg::REG_ROW0_PAIR, {e[1], e[0]});
        cfg_write(pir_pkg::REG_ROW0_ROW1, {e[3], e[2]});
        cfg_write(pir_pkg::REG_ROW1_PAIR, {e[5], e[4]});
        cfg_write(pir_pkg::REG_ROW2_PAIR, {e[7], e[6]});
        cfg_write(pir_pkg::REG_LAST, hi | 64'(32'(e[8])));
        case (mode)
            0: cfg_write(pir_pkg::REG_SRC_SIZE, hi | 64'hFFFF_FFFF);
            1: cfg_write(pir_pkg::REG_SRC_SIZE,
                hi | 64'({16'($urandom_range(8)), 16'd0}));
            default: cfg_write(pir_pkg::REG_SRC_SIZE,
                hi | 64'({16'($urandom_range(2, 8)), 16'($urandom_range(2, 8))}));
        endcase
        if (mode == 0) cfg_write(pir_pkg::REG_DST_SIZE, hi | 64'hFFFF_FFFF);
        else cfg_write(pir_pkg::REG_DST_SIZE,
            hi | 64'({16'($urandom_range(1, 10)), 16'($urandom_range(0, 10))}));
        cfg_write(pir_pkg::REG_BACKGROUND, hi | 64'($urandom));
        i_cfg_valid <= 0;
    endtask

    initial begin
        t_request q;
        int       sw, sh, dw, dh;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset config: destination height zero, so a map gives nothing
        send_request(make_req(pir_pkg::REQ_MAP, 0, 0, 5));
        // load far outside the store is dropped
        send_request(make_req(pir_pkg::REQ_LOAD, 16'hFFFF, 16'hFFFF, 7'h7F));
        drain();

        // directed: 4x4 source, 5x4 destination, 0.75 scale with small offset
        cfg_write(pir_pkg::REG_ROW0_PAIR, {32'd0, 32'h0000_C000});
        cfg_write(pir_pkg::REG_ROW0_ROW1, {32'd0, 32'h0000_1000});
        cfg_write(pir_pkg::REG_ROW1_PAIR, {32'h0000_1000, 32'h0000_C000});
        cfg_write(pir_pkg::REG_ROW2_PAIR, 64'd0);
        cfg_write(pir_pkg::REG_LAST, 64'h1_0000);
        cfg_write(pir_pkg::REG_SRC_SIZE, 64'h0004_0004);
        cfg_write(pir_pkg::REG_DST_SIZE, 64'h0004_0005);
        cfg_write(pir_pkg::REG_BACKGROUND, {32'd0, $urandom});
        i_cfg_valid <= 0;
        for (int y = 0; y < 4; y++)
            for (int x = 0; x < 4; x++) begin
                q = make_req(pir_pkg::REQ_LOAD, x, y, 0);
                if (x == 0 && y == 0) {q.blue, q.green, q.red, q.alpha} = '1;
                if (x == 1 && y == 0) {q.blue, q.green, q.red, q.alpha} = '0;
                send_request(q);
            end
        send_request(make_req(pir_pkg::REQ_MAP, 0, 0, 1));
        send_request(make_req(pir_pkg::REQ_MAP, 0, 0, 64));    // stops at the bottom row
        send_request(make_req(pir_pkg::REQ_MAP, 3, 1, 0));     // zero length
        send_request(make_req(pir_pkg::REQ_MAP, 7, 1, 3));     // start past the row end
        send_request(make_req(pir_pkg::REQ_MAP, 0, 4, 2));     // start below the image
        send_request(make_req(pir_pkg::REQ_MAP, 2, 3, 127));   // clamped length
        drain();
        // zero divisor everywhere
        cfg_write(pir_pkg::REG_LAST, 64'd0);
        i_cfg_valid <= 0;
        send_request(make_req(pir_pkg::REQ_MAP, 0, 0, 2));
        drain();

        // random phases; the second one runs without any idling
        for (int ph = 0; ph < 6; ph++) begin
            random_config(ph == 2 ? 0 : (ph == 4 ? 1 : 2));
            quiet = (ph == 1);
            sw = sb.regs[pir_pkg::REG_SRC_SIZE][15:0];  if (sw > SRC_MAX) sw = 8;
            sh = sb.regs[pir_pkg::REG_SRC_SIZE][31:16]; if (sh > SRC_MAX) sh = 8;
            dw = sb.regs[pir_pkg::REG_DST_SIZE][15:0];
            dh = sb.regs[pir_pkg::REG_DST_SIZE][31:16];
            for (int n = 0; n < 42; n++) begin
                if (n == 21) drain();
                case ($urandom_range(19))
                    0: q = make_req(pir_pkg::REQ_LOAD, $urandom, $urandom, $urandom);
                    1: q = make_req(pir_pkg::REQ_MAP, $urandom, $urandom, $urandom);
                    2: q = make_req(pir_pkg::REQ_MAP, $urandom_range(dw),
                                    $urandom_range(dh), 64);
                    3, 4, 5, 6, 7, 8:
                        q = make_req(pir_pkg::REQ_LOAD,
                                     $urandom_range(sw > 0 ? sw - 1 : 0),
                                     $urandom_range(sh > 0 ? sh - 1 : 0), $urandom);
                    default:
                        q = make_req(pir_pkg::REQ_MAP, $urandom_range(dw),
                                     $urandom_range(dh), $urandom_range(1, 8));
                endcase
                offer_request(q);
            end
            drain();
        end
        quiet = 0;

        if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
            $display("projective_image_resampler: match");
        end else begin
            $display("projective_image_resampler: mismatch");
        end
        $finish;
    end

endmodule
